[rtl/core/triangle_rotate_cull_shade_assert.svh]
// ----------------------------------------------------------------------------
// triangle_rotate_cull_shade assertion macros
// concurrent checks sampled on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_ROTATE_CULL_SHADE_ASSERT_SVH
`define TRIANGLE_ROTATE_CULL_SHADE_ASSERT_SVH

// same-cycle implication
`define TCS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

[rtl/core/tcs_pkg.sv]
// ----------------------------------------------------------------------------
// tcs_pkg
// widths, constants and types of the triangle rotate, cull and shade block
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int CW       = 16;  // config and input coordinate width
  localparam int RW       = 25;  // rotated coordinate, Q.8
  localparam int EW       = 26;  // edge vector
  localparam int XPW      = 52;  // cross product term
  localparam int NW       = 53;  // normal component
  localparam int LW       = 26;  // light vector component
  localparam int FIT_BITS = 20;
  localparam int FW       = 21;  // block-scaled component
  localparam int BLW      = 6;   // bit length count
  localparam int PW       = 42;  // scaled product
  localparam int DW       = 44;  // dot product sum
  localparam int SQW      = 42;  // squared length
  localparam int TW       = 44;  // root trial word
  localparam int RTW      = 21;  // root width
  localparam int NUMW     = 50;  // 255 * dot
  localparam int DVW      = 52;  // divider compare word
  localparam int QW       = 9;   // quotient bits
  localparam int SCW      = 31;  // screen transform word

  localparam int LIGHT_Y  = 50 * 256;
  localparam int LIGHT_Z  = 50 * 256;
  localparam int OFF_X    = 160 * 256;
  localparam int OFF_Y    = 120 * 256;
  localparam int SCALE    = 10;
  localparam int ROUND_Q4 = 8;
  localparam int ROUND_14 = 8192;
  localparam logic [7:0] SHADE_MAX = 8'd255;

  localparam int NUM_CFG = 6;
  localparam logic [2:0] CFG_COS_X = 3'd0;
  localparam logic [2:0] CFG_SIN_X = 3'd1;
  localparam logic [2:0] CFG_COS_Y = 3'd2;
  localparam logic [2:0] CFG_SIN_Y = 3'd3;
  localparam logic [2:0] CFG_COS_Z = 3'd4;
  localparam logic [2:0] CFG_SIN_Z = 3'd5;

  localparam logic signed [CW-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [1:0] VTX_FIRST = 2'd0;
  localparam logic [1:0] VTX_SECOND = 2'd1;
  localparam logic [1:0] VTX_LAST = 2'd2;

  typedef logic signed [RW-1:0] crd_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
    crd_t z;
  } vec_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic                 last;
    logic                 fend;
    logic                 dpos;
    logic [SQW-1:0]       dnum;
  } car_t;

endpackage

[rtl/core/triangle_rotate_cull_shade.sv]
// ----------------------------------------------------------------------------
// triangle_rotate_cull_shade
// rotates a triangle about x, y and z, culls back faces and gives three
// shaded screen vertices
// the first vertex word passes the rotation, edge, normal, shading, root,
//   divider and output registers; the other two vertex words follow it
// start is taken again on the last vertex, as set by the single vertex path
//   of the rotation pipeline and the single result port
// reset: synchronous active-low rst_n clears all valid bits and the
//   sequencers and loads the rotation registers with identity values
// ----------------------------------------------------------------------------
`include "triangle_rotate_cull_shade_assert.svh"

module triangle_rotate_cull_shade
  import tcs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_first_x,
  input  logic signed [CW-1:0] in_first_y,
  input  logic signed [CW-1:0] in_first_z,
  input  logic signed [CW-1:0] in_second_x,
  input  logic signed [CW-1:0] in_second_y,
  input  logic signed [CW-1:0] in_second_z,
  input  logic signed [CW-1:0] in_third_x,
  input  logic signed [CW-1:0] in_third_y,
  input  logic signed [CW-1:0] in_third_z,
  input  logic                 in_final_triangle,
  output logic                 out_valid,
  output logic signed [CW-1:0] out_screen_x,
  output logic signed [CW-1:0] out_screen_y,
  output logic signed [CW-1:0] out_depth,
  output logic [7:0]           out_shade,
  output logic                 out_last_vertex,
  output logic                 out_frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic signed [CW-1:0] cfg_data
);

  function automatic logic [BLW-1:0] bit_len(input logic [NW-1:0] m);
    logic [BLW-1:0] b;
    b = '0;
    for (int i = 0; i < NW; i++) begin
      if (m[i]) begin
        b = BLW'(i + 1);
      end
    end
    return b;
  endfunction

  function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
    logic [NW-1:0] r;
    r = v[NW-1] ? $unsigned(-v) : $unsigned(v);
    return r;
  endfunction

  function automatic logic signed [FW-1:0] fit_one(input logic signed [NW-1:0] v,
                                                   input logic [BLW-1:0] b);
    logic signed [NW-1:0] s;
    if (b > BLW'(FIT_BITS)) begin
      s = v >>> (b - BLW'(FIT_BITS));
    end else begin
      s = v <<< (BLW'(FIT_BITS) - b);
    end
    return s[FW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] to_screen(input crd_t v, input int off);
    logic signed [SCW-1:0] t;
    logic signed [SCW-5:0] sh;
    logic signed [CW-1:0]  r;
    t  = SCW'(v) * SCW'(SCALE) + SCW'(off) + SCW'(ROUND_Q4);
    sh = t[SCW-1:4];
    if (sh > (SCW-4)'(32767)) begin
      r = 16'sh7fff;
    end else if (sh < -(SCW-4)'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = sh[CW-1:0];
    end
    return r;
  endfunction

  // rotation registers
  logic signed [CW-1:0] cos_x_r, sin_x_r, cos_y_r, sin_y_r, cos_z_r, sin_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_x_r <= ONE_Q14;
      sin_x_r <= '0;
      cos_y_r <= ONE_Q14;
      sin_y_r <= '0;
      cos_z_r <= ONE_Q14;
      sin_z_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COS_X: cos_x_r <= cfg_data;
        CFG_SIN_X: sin_x_r <= cfg_data;
        CFG_COS_Y: cos_y_r <= cfg_data;
        CFG_SIN_Y: sin_y_r <= cfg_data;
        CFG_COS_Z: cos_z_r <= cfg_data;
        CFG_SIN_Z: sin_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word and vertex sequencer
  logic                 act_r;
  logic [1:0]           vidx_r;
  logic signed [CW-1:0] tx_r [3];
  logic signed [CW-1:0] ty_r [3];
  logic signed [CW-1:0] tz_r [3];
  logic                 fin_r;
  logic                 accept;

  assign busy   = act_r && (vidx_r != VTX_LAST);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      vidx_r <= VTX_FIRST;
    end else if (accept) begin
      act_r  <= 1'b1;
      vidx_r <= VTX_FIRST;
    end else if (act_r) begin
      if (vidx_r == VTX_LAST) begin
        act_r <= 1'b0;
      end else begin
        vidx_r <= vidx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_r[0] <= in_first_x;
      ty_r[0] <= in_first_y;
      tz_r[0] <= in_first_z;
      tx_r[1] <= in_second_x;
      ty_r[1] <= in_second_y;
      tz_r[1] <= in_second_z;
      tx_r[2] <= in_third_x;
      ty_r[2] <= in_third_y;
      tz_r[2] <= in_third_z;
      fin_r   <= in_final_triangle;
    end
  end

  // rotation pipeline, one vertex per cycle
  logic        r1_v_r, r2_v_r, r3_v_r, r4_v_r;
  logic [1:0]  r1_idx_r, r2_idx_r, r3_idx_r, r4_idx_r;
  logic        r1_fin_r, r2_fin_r, r3_fin_r, r4_fin_r;

  logic signed [CW-1:0] r1_x_r;
  logic signed [31:0]   r1_pa_r, r1_pb_r, r1_pc_r, r1_pd_r;
  logic signed [32:0]   s2a, s2b;
  logic signed [18:0]   y1_c, z1_c;
  logic signed [18:0]   r2_y1_r;
  logic signed [31:0]   r2_pa_r, r2_pd_r;
  logic signed [34:0]   r2_pb_r, r2_pc_r;
  logic signed [35:0]   s3a, s3b;
  logic signed [21:0]   x2_c, z2_c;
  logic signed [21:0]   r3_z2_r;
  logic signed [37:0]   r3_pa_r, r3_pc_r;
  logic signed [34:0]   r3_pb_r, r3_pd_r;
  logic signed [38:0]   s4a, s4b;
  vec_t                 r4_vec_r;

  assign s2a  = 33'(r1_pa_r) - 33'(r1_pb_r) + 33'(ROUND_14);
  assign s2b  = 33'(r1_pc_r) + 33'(r1_pd_r) + 33'(ROUND_14);
  assign y1_c = s2a[32:14];
  assign z1_c = s2b[32:14];
  assign s3a  = 36'(r2_pa_r) + 36'(r2_pb_r) + 36'(ROUND_14);
  assign s3b  = 36'(r2_pc_r) - 36'(r2_pd_r) + 36'(ROUND_14);
  assign x2_c = s3a[35:14];
  assign z2_c = s3b[35:14];
  assign s4a  = 39'(r3_pa_r) - 39'(r3_pb_r) + 39'(ROUND_14);
  assign s4b  = 39'(r3_pc_r) + 39'(r3_pd_r) + 39'(ROUND_14);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
      r4_v_r <= 1'b0;
    end else begin
      r1_v_r <= act_r;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
      r4_v_r <= r3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_idx_r <= vidx_r;
    r1_fin_r <= fin_r;
    r1_x_r   <= tx_r[vidx_r];
    r1_pa_r  <= ty_r[vidx_r] * cos_x_r;
    r1_pb_r  <= tz_r[vidx_r] * sin_x_r;
    r1_pc_r  <= ty_r[vidx_r] * sin_x_r;
    r1_pd_r  <= tz_r[vidx_r] * cos_x_r;

    r2_idx_r <= r1_idx_r;
    r2_fin_r <= r1_fin_r;
    r2_y1_r  <= y1_c;
    r2_pa_r  <= r1_x_r * cos_y_r;
    r2_pb_r  <= z1_c * sin_y_r;
    r2_pc_r  <= z1_c * cos_y_r;
    r2_pd_r  <= r1_x_r * sin_y_r;

    r3_idx_r <= r2_idx_r;
    r3_fin_r <= r2_fin_r;
    r3_z2_r  <= z2_c;
    r3_pa_r  <= x2_c * cos_z_r;
    r3_pb_r  <= r2_y1_r * sin_z_r;
    r3_pc_r  <= x2_c * sin_z_r;
    r3_pd_r  <= r2_y1_r * cos_z_r;

    r4_idx_r <= r3_idx_r;
    r4_fin_r <= r3_fin_r;
    r4_vec_r <= {s4a[38:14], s4b[38:14], RW'(r3_z2_r)};
  end

  // gather the three vertices, edges, normal
  vec_t h0_r, h1_r;
  logic e_v_r, n2_v_r;
  vec_t e_vert_r [3];
  vec_t n2_vert_r [3];
  logic e_fin_r, n2_fin_r;
  logic signed [EW-1:0]  e_u_r [3];
  logic signed [EW-1:0]  e_w_r [3];
  logic signed [XPW-1:0] n2_p_r [6];
  logic signed [NW-1:0]  nrm_c [3];
  logic                  t_load;

  always_ff @(posedge clk) begin
    if (r4_v_r && (r4_idx_r == VTX_FIRST)) begin
      h0_r <= r4_vec_r;
    end
    if (r4_v_r && (r4_idx_r == VTX_SECOND)) begin
      h1_r <= r4_vec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r  <= 1'b0;
      n2_v_r <= 1'b0;
    end else begin
      e_v_r  <= r4_v_r && (r4_idx_r == VTX_LAST);
      n2_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    e_vert_r[0] <= h0_r;
    e_vert_r[1] <= h1_r;
    e_vert_r[2] <= r4_vec_r;
    e_fin_r     <= r4_fin_r;
    e_u_r[0]    <= EW'(h1_r.x) - EW'(h0_r.x);
    e_u_r[1]    <= EW'(h1_r.y) - EW'(h0_r.y);
    e_u_r[2]    <= EW'(h1_r.z) - EW'(h0_r.z);
    e_w_r[0]    <= EW'(r4_vec_r.x) - EW'(h0_r.x);
    e_w_r[1]    <= EW'(r4_vec_r.y) - EW'(h0_r.y);
    e_w_r[2]    <= EW'(r4_vec_r.z) - EW'(h0_r.z);

    n2_vert_r <= e_vert_r;
    n2_fin_r  <= e_fin_r;
    n2_p_r[0] <= e_u_r[1] * e_w_r[2];
    n2_p_r[1] <= e_u_r[2] * e_w_r[1];
    n2_p_r[2] <= e_u_r[2] * e_w_r[0];
    n2_p_r[3] <= e_u_r[0] * e_w_r[2];
    n2_p_r[4] <= e_u_r[0] * e_w_r[1];
    n2_p_r[5] <= e_u_r[1] * e_w_r[0];
  end

  assign nrm_c[0] = NW'(n2_p_r[0]) - NW'(n2_p_r[1]);
  assign nrm_c[1] = NW'(n2_p_r[2]) - NW'(n2_p_r[3]);
  assign nrm_c[2] = NW'(n2_p_r[4]) - NW'(n2_p_r[5]);
  assign t_load   = n2_v_r && !nrm_c[2][NW-1];

  // triangle bank and vertex emitter
  vec_t                 t_vert_r [3];
  logic signed [NW-1:0] t_n_r [3];
  logic                 t_fin_r;
  logic                 em_act_r;
  logic [1:0]           em_idx_r;

  always_ff @(posedge clk) begin
    if (t_load) begin
      t_vert_r <= n2_vert_r;
      t_n_r    <= nrm_c;
      t_fin_r  <= n2_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_act_r <= 1'b0;
      em_idx_r <= VTX_FIRST;
    end else if (t_load) begin
      em_act_r <= 1'b1;
      em_idx_r <= VTX_FIRST;
    end else if (em_act_r) begin
      if (em_idx_r == VTX_LAST) begin
        em_act_r <= 1'b0;
      end else begin
        em_idx_r <= em_idx_r + 2'd1;
      end
    end
  end

  // shading front: light vector, screen map, block scaling, products
  vec_t                 pv_c;
  logic signed [LW-1:0] l_c [3];
  car_t                 car0_c;

  logic                 s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  car_t                 s0_car_r, s1_car_r, s2_car_r, s3_car_r;
  logic signed [LW-1:0] s0_l_r [3];
  logic signed [LW-1:0] s1_l_r [3];
  logic signed [NW-1:0] s0_n_r [3];
  logic signed [NW-1:0] s1_n_r [3];
  logic [LW-1:0]        s0_orl_r;
  logic [NW-1:0]        s0_orn_r;
  logic [BLW-1:0]       s1_bl_r, s1_bn_r;
  logic signed [FW-1:0] s2_lf_r [3];
  logic signed [FW-1:0] s2_nf_r [3];
  logic signed [PW-1:0] s3_d_r [3];
  logic signed [PW-1:0] s3_ql_r [3];
  logic signed [PW-1:0] s3_qn_r [3];
  logic signed [DW-1:0] dot_c, sql_c, sqn_c;

  assign pv_c   = t_vert_r[em_idx_r];
  assign l_c[0] = -LW'(pv_c.x);
  assign l_c[1] = LW'(LIGHT_Y) - LW'(pv_c.y);
  assign l_c[2] = LW'(LIGHT_Z) - LW'(pv_c.z);

  always_comb begin
    car0_c      = '0;
    car0_c.sx   = to_screen(pv_c.x, OFF_X);
    car0_c.sy   = to_screen(pv_c.y, OFF_Y);
    car0_c.sz   = to_screen(pv_c.z, 0);
    car0_c.last = (em_idx_r == VTX_LAST);
    car0_c.fend = (em_idx_r == VTX_LAST) && t_fin_r;
  end

  assign dot_c = DW'(s3_d_r[0]) + DW'(s3_d_r[1]) + DW'(s3_d_r[2]);
  assign sql_c = DW'(s3_ql_r[0]) + DW'(s3_ql_r[1]) + DW'(s3_ql_r[2]);
  assign sqn_c = DW'(s3_qn_r[0]) + DW'(s3_qn_r[1]) + DW'(s3_qn_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= em_act_r;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_car_r <= car0_c;
    s0_l_r   <= l_c;
    s0_n_r   <= t_n_r;
    s0_orl_r <= LW'(mag(NW'(l_c[0])) | mag(NW'(l_c[1])) | mag(NW'(l_c[2])));
    s0_orn_r <= mag(t_n_r[0]) | mag(t_n_r[1]) | mag(t_n_r[2]);

    s1_car_r <= s0_car_r;
    s1_l_r   <= s0_l_r;
    s1_n_r   <= s0_n_r;
    s1_bl_r  <= bit_len(NW'(s0_orl_r));
    s1_bn_r  <= bit_len(s0_orn_r);

    s2_car_r <= s1_car_r;
    for (int i = 0; i < 3; i++) begin
      s2_lf_r[i] <= fit_one(NW'(s1_l_r[i]), s1_bl_r);
      s2_nf_r[i] <= fit_one(s1_n_r[i], s1_bn_r);
    end

    s3_car_r <= s2_car_r;
    for (int i = 0; i < 3; i++) begin
      s3_d_r[i]  <= s2_lf_r[i] * s2_nf_r[i];
      s3_ql_r[i] <= s2_lf_r[i] * s2_lf_r[i];
      s3_qn_r[i] <= s2_nf_r[i] * s2_nf_r[i];
    end
  end

  // floor square roots, one root bit per stage
  logic           sq_v_r   [0:RTW];
  car_t           sq_car_r [0:RTW];
  logic [SQW-1:0] sq_reml_r [0:RTW];
  logic [SQW-1:0] sq_remn_r [0:RTW];
  logic [RTW-1:0] sq_rtl_r  [0:RTW];
  logic [RTW-1:0] sq_rtn_r  [0:RTW];
  car_t           sq0_car_c;

  always_comb begin
    sq0_car_c      = s3_car_r;
    sq0_car_c.dpos = !dot_c[DW-1] && (dot_c != '0);
    sq0_car_c.dnum = dot_c[SQW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_car_r[0]  <= sq0_car_c;
    sq_reml_r[0] <= sql_c[SQW-1:0];
    sq_remn_r[0] <= sqn_c[SQW-1:0];
    sq_rtl_r[0]  <= '0;
    sq_rtn_r[0]  <= '0;
  end

  for (genvar s = 0; s < RTW; s++) begin : g_sqrt
    localparam int K = RTW - 1 - s;
    logic [TW-1:0] trl, trn;
    assign trl = (TW'(sq_rtl_r[s]) << (K + 1)) + (TW'(1) << (2 * K));
    assign trn = (TW'(sq_rtn_r[s]) << (K + 1)) + (TW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[s+1] <= 1'b0;
      end else begin
        sq_v_r[s+1] <= sq_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      sq_car_r[s+1] <= sq_car_r[s];
      if (TW'(sq_reml_r[s]) >= trl) begin
        sq_reml_r[s+1] <= sq_reml_r[s] - trl[SQW-1:0];
        sq_rtl_r[s+1]  <= sq_rtl_r[s] | (RTW'(1) << K);
      end else begin
        sq_reml_r[s+1] <= sq_reml_r[s];
        sq_rtl_r[s+1]  <= sq_rtl_r[s];
      end
      if (TW'(sq_remn_r[s]) >= trn) begin
        sq_remn_r[s+1] <= sq_remn_r[s] - trn[SQW-1:0];
        sq_rtn_r[s+1]  <= sq_rtn_r[s] | (RTW'(1) << K);
      end else begin
        sq_remn_r[s+1] <= sq_remn_r[s];
        sq_rtn_r[s+1]  <= sq_rtn_r[s];
      end
    end
  end

  // ratio 255*dot / (len_l*len_n), one quotient bit per stage
  logic            dv_v_r   [0:QW];
  car_t            dv_car_r [0:QW];
  logic [NUMW-1:0] dv_rem_r [0:QW];
  logic [SQW-1:0]  dv_den_r [0:QW];
  logic [QW-1:0]   dv_q_r   [0:QW];
  logic            dv_ovf_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[RTW];
    end
  end

  always_ff @(posedge clk) begin
    dv_car_r[0] <= sq_car_r[RTW];
    dv_den_r[0] <= SQW'(sq_rtl_r[RTW]) * SQW'(sq_rtn_r[RTW]);
    dv_rem_r[0] <= (NUMW'(sq_car_r[RTW].dnum) << 8) - NUMW'(sq_car_r[RTW].dnum);
    dv_q_r[0]   <= '0;
    dv_ovf_r[0] <= 1'b0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic [DVW-1:0] sub;
    logic           ovf;
    assign sub = DVW'(dv_den_r[s]) << K;
    assign ovf = (s == 0) ? (DVW'(dv_rem_r[s]) >= (DVW'(dv_den_r[s]) << QW))
                          : dv_ovf_r[s];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[s+1] <= 1'b0;
      end else begin
        dv_v_r[s+1] <= dv_v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      dv_car_r[s+1] <= dv_car_r[s];
      dv_den_r[s+1] <= dv_den_r[s];
      dv_ovf_r[s+1] <= ovf;
      if (DVW'(dv_rem_r[s]) >= sub) begin
        dv_rem_r[s+1] <= dv_rem_r[s] - sub[NUMW-1:0];
        dv_q_r[s+1]   <= dv_q_r[s] | (QW'(1) << K);
      end else begin
        dv_rem_r[s+1] <= dv_rem_r[s];
        dv_q_r[s+1]   <= dv_q_r[s];
      end
    end
  end

  // result word
  car_t       fcar_c;
  logic [7:0] shade_c;
  logic       out_valid_r;
  car_t       out_car_r;
  logic [7:0] out_shade_r;

  assign fcar_c = dv_car_r[QW];

  always_comb begin
    if (!fcar_c.dpos) begin
      shade_c = '0;
    end else if (dv_ovf_r[QW] || dv_q_r[QW][QW-1]) begin
      shade_c = SHADE_MAX;
    end else begin
      shade_c = dv_q_r[QW][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_car_r   <= fcar_c;
    out_shade_r <= shade_c;
  end

  assign out_valid       = out_valid_r;
  assign out_screen_x    = out_car_r.sx;
  assign out_screen_y    = out_car_r.sy;
  assign out_depth       = out_car_r.sz;
  assign out_shade       = out_shade_r;
  assign out_last_vertex = out_car_r.last;
  assign out_frame_end   = out_car_r.fend;

  `TCS_ASSERT_NEXT(a_busy_window, start && !busy, busy ##1 busy ##1 !busy, "busy window not two cycles")
  `TCS_ASSERT_IMPL(a_emit_reload, t_load, !em_act_r || em_idx_r == VTX_LAST, "triangle bank overwritten")
  `TCS_ASSERT_IMPL(a_vertex_group, out_valid && out_last_vertex, $past(out_valid) && $past(out_valid, 2) && !$past(out_last_vertex), "last vertex without two before it")

endmodule

[tb/sv/triangle_rotate_cull_shade_tb.sv]
// ----------------------------------------------------------------------------
// triangle_rotate_cull_shade_tb
// Drives triangles through the rotate, cull and shade block under several
// rotation register settings and with random idle gaps on the start side.
// A short stimulus table covers reset values, coordinate extremes, back
// faces, degenerate triangles and a vertex at the light. Random triangles
// follow. Every vertex word is checked field by field: degenerate rows
// against the table, the rest against a bit-exact predictor in the bench.
// ----------------------------------------------------------------------------
module triangle_rotate_cull_shade_tb;
  import tcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int ITEMS_PER_SET  = 50;
  localparam int NUM_SETS       = 9;

  typedef struct packed {
    logic [8:0][CW-1:0] crd;
    logic               fin;
  } tri_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic [7:0]           shade;
    logic                 last;
    logic                 fend;
  } vtx_t;

  typedef struct packed {
    tri_t                 face;
    logic                 known;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] in_crd [9];
  logic                 in_final_triangle = 1'b0;
  logic                 out_valid;
  logic signed [CW-1:0] out_screen_x, out_screen_y, out_depth;
  logic [7:0]           out_shade;
  logic                 out_last_vertex, out_frame_end;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [2:0]           cfg_index = '0;
  logic signed [CW-1:0] cfg_data = '0;

  longint rot_reg [NUM_CFG];
  vtx_t   vertex_q [$];
  int     mismatches = 0;
  int     words_seen = 0;
  int     tris_sent  = 0;
  int     idle_cnt   = 0;
  int     gap_pct    = 0;

  initial foreach (in_crd[i]) in_crd[i] = '0;

  always #5 clk = ~clk;

  triangle_rotate_cull_shade dut (
    .clk, .rst_n, .start, .busy,
    .in_first_x (in_crd[0]), .in_first_y (in_crd[1]), .in_first_z (in_crd[2]),
    .in_second_x(in_crd[3]), .in_second_y(in_crd[4]), .in_second_z(in_crd[5]),
    .in_third_x (in_crd[6]), .in_third_y (in_crd[7]), .in_third_z (in_crd[8]),
    .in_final_triangle,
    .out_valid, .out_screen_x, .out_screen_y, .out_depth, .out_shade,
    .out_last_vertex, .out_frame_end,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  function automatic longint rotate(longint a, longint c, longint b, longint s, bit plus);
    longint sum;
    sum = plus ? a * c + b * s : a * c - b * s;
    return (sum + ROUND_14) >>> 14;
  endfunction

  function automatic logic signed [CW-1:0] to_screen(longint v, longint off);
    longint r;
    r = (v * SCALE + off + ROUND_Q4) >>> 4;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[CW-1:0];
  endfunction

  function automatic void block_scale(ref longint v [3]);
    longint m, a;
    int b;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a = v[i] < 0 ? -v[i] : v[i];
      if (a > m) m = a;
    end
    if (m == 0) return;
    b = 0;
    while (m != 0) begin
      b++;
      m = m >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (b > FIT_BITS) v[i] = v[i] >>> (b - FIT_BITS);
      else if (b < FIT_BITS) v[i] = v[i] <<< (FIT_BITS - b);
    end
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned r, bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (n >= r + bit_w) begin
        n = n - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic [7:0] lambert(longint p [3], longint nrm [3]);
    longint l [3], n [3];
    longint d, ll, ln, den, q;
    l[0] = -p[0];
    l[1] = LIGHT_Y - p[1];
    l[2] = LIGHT_Z - p[2];
    n = nrm;
    block_scale(l);
    block_scale(n);
    d = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
    if (d <= 0) return 8'd0;
    ll = floor_sqrt(l[0] * l[0] + l[1] * l[1] + l[2] * l[2]);
    ln = floor_sqrt(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
    den = ll * ln;
    if (den == 0) return 8'd0;
    q = (d * 255) / den;
    return q > 255 ? SHADE_MAX : q[7:0];
  endfunction

  // rotates, culls and shades one triangle, queueing its vertex words
  function automatic void predict_vertices(tri_t t);
    longint v [3][3];
    longint e1 [3], e2 [3], nrm [3];
    longint x, y, z, y1, z1, x2, z2;
    vtx_t w;
    for (int j = 0; j < 3; j++) begin
      x  = longint'($signed(t.crd[3*j]));
      y  = longint'($signed(t.crd[3*j+1]));
      z  = longint'($signed(t.crd[3*j+2]));
      y1 = rotate(y, rot_reg[CFG_COS_X], z, rot_reg[CFG_SIN_X], 1'b0);
      z1 = rotate(y, rot_reg[CFG_SIN_X], z, rot_reg[CFG_COS_X], 1'b1);
      x2 = rotate(x, rot_reg[CFG_COS_Y], z1, rot_reg[CFG_SIN_Y], 1'b1);
      z2 = rotate(z1, rot_reg[CFG_COS_Y], x, rot_reg[CFG_SIN_Y], 1'b0);
      v[j][0] = rotate(x2, rot_reg[CFG_COS_Z], y1, rot_reg[CFG_SIN_Z], 1'b0);
      v[j][1] = rotate(x2, rot_reg[CFG_SIN_Z], y1, rot_reg[CFG_COS_Z], 1'b1);
      v[j][2] = z2;
    end
    for (int j = 0; j < 3; j++) begin
      e1[j] = v[1][j] - v[0][j];
      e2[j] = v[2][j] - v[0][j];
    end
    nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (nrm[2] < 0) return;
    for (int j = 0; j < 3; j++) begin
      w.sx    = to_screen(v[j][0], OFF_X);
      w.sy    = to_screen(v[j][1], OFF_Y);
      w.sz    = to_screen(v[j][2], 0);
      w.shade = lambert(v[j], nrm);
      w.last  = (j == 2);
      w.fend  = (j == 2) && t.fin;
      vertex_q.push_back(w);
    end
  endfunction

  function automatic logic [CW-1:0] pick_coord();
    logic [CW-1:0] extremes [6] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'd12800,
                                    16'h0001};
    case ($urandom % 10)
      0, 1, 2: return CW'($urandom);
      8:       return extremes[$urandom % 6];
      9:       return CW'($urandom_range(0, 128) - 64);
      default: return CW'($urandom_range(0, 4096) - 2048);
    endcase
  endfunction

  function automatic tri_t random_tri();
    tri_t t;
    foreach (t.crd[k]) t.crd[k] = pick_coord();
    t.fin = $urandom_range(0, 3) == 0;
    return t;
  endfunction

  task automatic send_tri(tri_t t, bit known, vtx_t typed);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    foreach (in_crd[k]) in_crd[k] <= t.crd[k];
    in_final_triangle <= t.fin;
    do @(posedge clk); while (busy);
    tris_sent++;
    if (known) begin
      for (int j = 0; j < 3; j++) begin
        typed.last = (j == 2);
        typed.fend = (j == 2) && t.fin;
        vertex_q.push_back(typed);
      end
    end else begin
      predict_vertices(t);
    end
  endtask

  // writes all six rotation registers plus the two unused indexes
  task automatic load_rotation(longint vals [NUM_CFG]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= i < NUM_CFG ? vals[i][CW-1:0] : CW'($urandom);
      do @(posedge clk); while (!cfg_ready);
      if (i < NUM_CFG) rot_reg[i] = longint'($signed(vals[i][CW-1:0]));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // vertex word checker
  always @(posedge clk) begin
    vtx_t e;
    if (rst_n && out_valid) begin
      words_seen++;
      if (vertex_q.size() == 0) begin
        $display("%0t: unexpected vertex word, expected none, actual x=%0d y=%0d", $time,
                 out_screen_x, out_screen_y);
        mismatches++;
      end else begin
        e = vertex_q.pop_front();
        if (out_screen_x !== e.sx) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, out_screen_x);
          mismatches++;
        end
        if (out_screen_y !== e.sy) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, out_screen_y);
          mismatches++;
        end
        if (out_depth !== e.sz) begin
          $display("%0t: depth expected %0d actual %0d", $time, e.sz, out_depth);
          mismatches++;
        end
        if (out_shade !== e.shade) begin
          $display("%0t: shade expected %0d actual %0d", $time, e.shade, out_shade);
          mismatches++;
        end
        if (out_last_vertex !== e.last) begin
          $display("%0t: last_vertex expected %0b actual %0b", $time, e.last,
                   out_last_vertex);
          mismatches++;
        end
        if (out_frame_end !== e.fend) begin
          $display("%0t: frame_end expected %0b actual %0b", $time, e.fend, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    row_t   dir_rows [$];
    row_t   r;
    vtx_t   typed;
    longint rot_set [NUM_CFG];
    int     gap_by_set [4];

    gap_by_set = '{0, 61, 0, 29};
    rot_reg = '{16384, 0, 16384, 0, 16384, 0};

    // degenerate triangles at identity rotation: position read off directly
    r = '0; r.known = 1'b1; r.face.fin = 1'b1; r.sx = 2560; r.sy = 1920; r.sz = 0;
    dir_rows.push_back(r);
    r = '0; r.known = 1'b1; foreach (r.face.crd[k]) r.face.crd[k] = 16'h7fff;
    r.sx = 23039; r.sy = 22399; r.sz = 20479;
    dir_rows.push_back(r);
    r = '0; r.known = 1'b1; r.face.fin = 1'b1;
    foreach (r.face.crd[k]) r.face.crd[k] = 16'h8000;
    r.sx = -17920; r.sy = -18560; r.sz = -20480;
    dir_rows.push_back(r);
    // front face, back face, back face ending a frame
    r = '0; r.face.crd[3] = 256; r.face.crd[7] = 256;
    dir_rows.push_back(r);
    r = '0; r.face.crd[6] = 256; r.face.crd[4] = 256;
    dir_rows.push_back(r);
    r.face.fin = 1'b1;
    dir_rows.push_back(r);
    // vertex sitting on the light
    r = '0; r.face.crd[1] = 12800; r.face.crd[2] = 12800; r.face.crd[3] = 256;
    r.face.crd[4] = 12800; r.face.crd[5] = 12800; r.face.crd[7] = 13056;
    r.face.crd[8] = 12800; r.face.fin = 1'b1;
    dir_rows.push_back(r);
    // mixed extremes, front and back
    r = '0; r.face.crd = {16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'hffff,
                          16'h0001, 16'h8000, 16'h7fff};
    dir_rows.push_back(r);
    r.face.crd = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0001,
                  16'hffff, 16'h7fff, 16'h8000};
    r.face.fin = 1'b1;
    dir_rows.push_back(r);
    r = '0; r.face.crd = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff,
                          16'h0000, 16'h7fff, 16'h0000};
    dir_rows.push_back(r);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed = '0;
      typed.sx = dir_rows[i].sx;
      typed.sy = dir_rows[i].sy;
      typed.sz = dir_rows[i].sz;
      send_tri(dir_rows[i].face, dir_rows[i].known, typed);
    end

    for (int s = 0; s < NUM_SETS; s++) begin
      start <= 1'b0;
      wait_idle();
      for (int i = 0; i < NUM_CFG; i++) begin
        case (s)
          0:       rot_set[i] = (i % 2) ? 16384 : 0;
          1:       rot_set[i] = (i % 2) ? 0 : -16384;
          2:       rot_set[i] = 16384;
          3:       rot_set[i] = -16384;
          4, 5:    rot_set[i] = $urandom_range(0, 32768) - 16384;
          6:       rot_set[i] = longint'($signed(CW'($urandom)));
          7:       rot_set[i] = (i % 2) ? 11585 : -11585;
          default: rot_set[i] = (i % 2) ? 0 : 16384;
        endcase
      end
      load_rotation(rot_set);
      gap_pct = gap_by_set[s % 4];
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        send_tri(random_tri(), 1'b0, '0);
      end
    end
    start <= 1'b0;
    wait_idle();

    $display("%0d triangles sent, %0d vertex words checked", tris_sent, words_seen);
    $display("rotation settings: identity, quarter and half turns, extremes, random");
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[triangle_rotate_cull_shade.f]
+incdir+rtl/core
rtl/core/tcs_pkg.sv
rtl/core/triangle_rotate_cull_shade.sv
tb/sv/triangle_rotate_cull_shade_tb.sv
